// ===== src/transfer_frame_header_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Transfer frame header parser assertion macros
// Shared concurrent assertion forms used by the parser's RTL modules.
// ----------------------------------------------------------------------------
`ifndef TRANSFER_FRAME_HEADER_PARSER_MACROS_SVH
`define TRANSFER_FRAME_HEADER_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFHP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFHP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tfhp_pkg.sv =====
// ----------------------------------------------------------------------------
// Transfer frame header parser package
// Types, layout constants and small decode functions shared by the parser.
// ----------------------------------------------------------------------------
package tfhp_pkg;

   // Header layout in bytes.
   localparam int unsigned PRIMARY_BYTES   = 4;
   localparam int unsigned EXT_FIXED_BYTES = 3;
   localparam int unsigned MAX_SEQ_BYTES   = 7;

   // Width of the header size sum and the saturation limit of the data size.
   localparam int unsigned HDR_W    = 17;
   localparam logic [15:0] DATA_MAX = 16'hFFFF;

   // Frame class codes derived from the bypass and command flags.
   typedef enum logic [1:0] {
      CLASS_EXP_PAYLOAD  = 2'd0,
      CLASS_EXP_COMMAND  = 2'd1,
      CLASS_CTRL_PAYLOAD = 2'd2,
      CLASS_RESERVED     = 2'd3
   } svc_class_type;

   // Header fields collected while a frame streams in.
   typedef struct packed {
      logic [31:0] primary_word;
      logic [15:0] length_field;
      logic [7:0]  flag_byte;
      logic [55:0] sequence_accum;
   } frame_fields_type;

   // One parsed result; the first field sits in the highest bits.
   typedef struct packed {
      logic [15:0]     data_size;
      logic [16:0]     frame_length;
      logic [55:0]     sequence_number;
      logic [2:0]      seq_length;
      logic            ocf_flag;
      svc_class_type   svc_class;
      logic            extended;
      logic            is_destination;
      logic [3:0]      map_id;
      logic [5:0]      virtual_channel;
      logic [7:0]      spacecraft_id;
      logic [3:0]      version_number;
   } result_type;

   // Sequence number byte count from the flag byte, clamped to the maximum.
   function automatic logic [2:0] seq_bytes_of(input logic [7:0] flags);
      logic [2:0] n;
      n = flags[2:0];
      if (n > 3'(MAX_SEQ_BYTES)) begin
         n = 3'(MAX_SEQ_BYTES);
      end
      return n;
   endfunction

   // Frame class from the bypass and command flags.
   function automatic svc_class_type class_of(input logic bypass, input logic command);
      svc_class_type cls;
      case ({bypass, command})
         2'b10:   cls = CLASS_EXP_PAYLOAD;
         2'b11:   cls = CLASS_EXP_COMMAND;
         2'b00:   cls = CLASS_CTRL_PAYLOAD;
         default: cls = CLASS_RESERVED;
      endcase
      return cls;
   endfunction

endpackage

// ===== src/tfhp_capture.sv =====
// ----------------------------------------------------------------------------
// Transfer frame header parser field capture
// Holds the byte counter and header fields, and works out their values after
// the current byte.
// ----------------------------------------------------------------------------
`include "transfer_frame_header_parser_macros.svh"

module tfhp_capture #(
   parameter int unsigned MAX_FRAME_BYTES = 65536,
   parameter int unsigned CountW          = $clog2(MAX_FRAME_BYTES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 frame_byte,
   input  logic                       last_byte,
   output tfhp_pkg::frame_fields_type fields_next,
   output logic [CountW-1:0]          count_next
);
   import tfhp_pkg::*;

   frame_fields_type  fields_ff;
   logic [CountW-1:0] count_ff;
   logic              ext_prev;
   logic [CountW-1:0] seq_end;

   // Header bytes go to their fields according to their position in the frame.
   always_comb begin
      fields_next = fields_ff;
      ext_prev    = ~fields_ff.primary_word[0];
      seq_end     = CountW'(PRIMARY_BYTES + EXT_FIXED_BYTES)
                    + CountW'(seq_bytes_of(fields_ff.flag_byte));
      if (count_ff < CountW'(PRIMARY_BYTES)) begin
         case (count_ff[1:0])
            2'd0:    fields_next.primary_word[31:24] = frame_byte;
            2'd1:    fields_next.primary_word[23:16] = frame_byte;
            2'd2:    fields_next.primary_word[15:8]  = frame_byte;
            default: fields_next.primary_word[7:0]   = frame_byte;
         endcase
      end else if (ext_prev) begin
         if (count_ff == CountW'(PRIMARY_BYTES)) begin
            fields_next.length_field[15:8] = frame_byte;
         end else if (count_ff == CountW'(PRIMARY_BYTES + 1)) begin
            fields_next.length_field[7:0] = frame_byte;
         end else if (count_ff == CountW'(PRIMARY_BYTES + 2)) begin
            fields_next.flag_byte = frame_byte;
         end else if (count_ff < seq_end) begin
            fields_next.sequence_accum = {fields_ff.sequence_accum[47:0], frame_byte};
         end
      end
   end

   // The byte counter stops at the largest frame size.
   assign count_next = (count_ff == CountW'(MAX_FRAME_BYTES)) ? count_ff
                                                               : count_ff + 1'b1;

   // Frame state is cleared after the final byte of each frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         if (last_byte) begin
            fields_ff <= '0;
            count_ff  <= '0;
         end else begin
            fields_ff <= fields_next;
            count_ff  <= count_next;
         end
      end
   end

   `TFHP_ASSERT_NXT(a_count_cleared, clock, reset, step && last_byte, count_ff == '0, "byte count not cleared after final byte")
   `TFHP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CountW'(MAX_FRAME_BYTES), "byte count beyond frame limit")

endmodule

// ===== src/tfhp_result.sv =====
// ----------------------------------------------------------------------------
// Transfer frame header parser result stage
// Decodes the finished header fields, works out the data size and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module tfhp_result #(
   parameter int unsigned MAX_FRAME_BYTES = 65536,
   parameter int unsigned CountW          = $clog2(MAX_FRAME_BYTES + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  tfhp_pkg::frame_fields_type fields,
   input  logic [CountW-1:0]          total,
   input  logic [15:0]                ins_len,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output tfhp_pkg::result_type       result
);
   import tfhp_pkg::*;

   localparam int unsigned SumW = (CountW > HDR_W) ? CountW : HDR_W;

   logic              ext;
   logic [2:0]        nseq;
   logic [HDR_W-1:0]  hdr_size;
   logic [SumW-1:0]   total_ext;
   logic [SumW-1:0]   hdr_ext;
   logic [SumW-1:0]   diff;
   logic [15:0]       data_size;
   result_type        result_in;
   result_type        result_ff;
   logic              valid_ff;

   // Header size and the saturating data size.
   always_comb begin
      ext      = ~fields.primary_word[0];
      nseq     = ext ? seq_bytes_of(fields.flag_byte) : 3'd0;
      hdr_size = HDR_W'(PRIMARY_BYTES);
      if (ext) begin
         hdr_size = hdr_size + HDR_W'(EXT_FIXED_BYTES) + HDR_W'(nseq)
                    + HDR_W'(ins_len);
      end
      total_ext = SumW'(total);
      hdr_ext   = SumW'(hdr_size);
      diff      = total_ext - hdr_ext;
      if (total_ext <= hdr_ext) begin
         data_size = '0;
      end else if (diff > SumW'(DATA_MAX)) begin
         data_size = DATA_MAX;
      end else begin
         data_size = diff[15:0];
      end
   end

   // Field decode; extended-header fields read zero when there is none.
   always_comb begin
      result_in.version_number  = fields.primary_word[31:28];
      result_in.spacecraft_id   = fields.primary_word[19:12];
      result_in.virtual_channel = fields.primary_word[10:5];
      result_in.map_id          = fields.primary_word[4:1];
      result_in.is_destination  = fields.primary_word[11];
      result_in.extended        = ext;
      result_in.data_size       = data_size;
      if (ext) begin
         result_in.svc_class       = class_of(fields.flag_byte[7], fields.flag_byte[6]);
         result_in.ocf_flag        = fields.flag_byte[3];
         result_in.seq_length      = nseq;
         result_in.sequence_number = fields.sequence_accum;
         result_in.frame_length    = {1'b0, fields.length_field} + 17'd1;
      end else begin
         result_in.svc_class       = CLASS_EXP_PAYLOAD;
         result_in.ocf_flag        = 1'b0;
         result_in.seq_length      = 3'd0;
         result_in.sequence_number = '0;
         result_in.frame_length    = '0;
      end
   end

   // Result register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign result     = result_ff;

endmodule

// ===== src/transfer_frame_header_parser.sv =====
// ----------------------------------------------------------------------------
// Transfer frame header parser
// Streams a transfer frame in byte by byte and reports its decoded header.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle while req_tready is high. Each
// byte is held in an input register and its header field is then captured in
// the field registers; on the byte marked tlast the decoded header leaves
// through the result register. The loop through the byte counter and field
// registers sets the rate of one byte per cycle; input ready drops only while
// a final byte waits behind a result that the downstream side has not yet
// taken. The user must write the insert zone length through the csr port only
// while no frame is in flight; the block itself does not enforce it.
`include "transfer_frame_header_parser_macros.svh"

module transfer_frame_header_parser #(
   parameter int unsigned MAX_FRAME_BYTES = 65536
) (
   input  logic          clock,
   input  logic          reset,
   // Frame bytes: tdata[7:0] frame_byte; tlast is last_byte.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,
   // Results: tdata[3:0] version_number, [11:4] spacecraft_id,
   // [17:12] virtual_channel, [21:18] map_id, [22] is_destination,
   // [23] extended, [25:24] svc_class, [26] ocf_flag,
   // [29:27] seq_length, [85:30] sequence_number, [102:86] frame_length,
   // [118:103] data_size, [119] zero.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,
   // Insert zone length register.
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);
   import tfhp_pkg::*;

   localparam int unsigned CountW = $clog2(MAX_FRAME_BYTES + 1);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic [15:0]       ins_len_ff;
   logic              advance;
   logic              req_accept;
   frame_fields_type  fields_next;
   logic [CountW-1:0] count_next;
   result_type        result;

   // A held byte moves on unless it ends a frame and the result slot is full and not being taken.
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Insert zone length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_len_ff <= '0;
      end else if (csr_wr_en) begin
         ins_len_ff <= csr_wr_data;
      end
   end

   // Field capture.
   tfhp_capture #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .CountW          (CountW)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .frame_byte  (in_byte_ff),
      .last_byte   (in_last_ff),
      .fields_next (fields_next),
      .count_next  (count_next)
   );

   // Decode and result register.
   tfhp_result #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .CountW          (CountW)
   ) u_result (
      .clock              (clock),
      .reset              (reset),
      .load               (advance && in_last_ff),
      .fields             (fields_next),
      .total              (count_next),
      .ins_len            (ins_len_ff),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .result             (result)
   );

   assign rsp_tdata = {1'b0, result};

   `TFHP_ASSERT_NXT(a_final_gives_result, clock, reset, advance && in_last_ff, rsp_tvalid, "final byte did not produce a result")
   `TFHP_ASSERT_NXT(a_no_spurious_result, clock, reset, rsp_tvalid && rsp_tready && !(advance && in_last_ff), !rsp_tvalid, "result appeared without a final byte")

endmodule
